>>> hw/rtl/rid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_pkg: shared types and constants for the radix integer to digits block
// Holds field widths, radix limits, ASCII anchors, the job word passed from
// front to back, the back-end state type and the digit to character mapping.
// ----------------------------------------------------------------------------
package rid_pkg;

   localparam int VALUE_W     = 32;
   localparam int DIGIT_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int RADIX_W     = 6;

   // divide step: bits of quotient produced per clock
   localparam int STEP_BITS   = 8;
   localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;   // '0'
   localparam logic [CHAR_W-1:0]  CHAR_UPPER  = 7'h41;   // 'A'
   localparam logic [CHAR_W-1:0]  CHAR_LOWER  = 7'h61;   // 'a'

   localparam logic [DIGIT_W-1:0] DIGIT_UPPER_BASE = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_LOWER_BASE = 6'd36;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] base;
   } rid_job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_LOAD,
      BK_SHOW
   } rid_back_state_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_UPPER_BASE) begin
         c = CHAR_ZERO + {1'b0, d};
      end else if (d < DIGIT_LOWER_BASE) begin
         c = CHAR_UPPER + {1'b0, d - DIGIT_UPPER_BASE};
      end else begin
         c = CHAR_LOWER + {1'b0, d - DIGIT_LOWER_BASE};
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/rid_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid channels: valid/ready interfaces of the radix integer to digits block
// rid_req_if carries the value to convert, rid_rsp_if one digit character.
// ----------------------------------------------------------------------------
interface rid_req_if
   import rid_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rid_rsp_if
   import rid_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> hw/rtl/radix_integer_to_digits_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_digits_top: unsigned 32-bit value to ASCII digit string
// Converts each value to its digits in the configured radix, most
// significant first, with last_digit set on the final character.
// ----------------------------------------------------------------------------
// Each value on req_bus becomes one word per digit on rsp_bus, most
// significant first; zero gives a single '0'. Digits 0-9 map to '0'-'9',
// 10-35 to 'A'-'Z' and 36-61 to 'a'-'z'. The radix is written on csr_wr_data
// with csr_wr_en; values below 2 act as 2 and 63 acts as 62; reset radix is
// 10. Each value is popped from the queue, divided by the radix once per digit
// with each remainder stored, and the first digit read back; the digits then
// leave one a cycle while rsp_bus is ready. The divider forms eight quotient
// bits a cycle. A two-entry queue in the front takes new values while the
// back end is busy. Only the MAX_DIGITS least significant digits of a value
// are kept.
module radix_integer_to_digits_top
   import rid_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [RADIX_W-1:0] csr_wr_data,
   rid_req_if.sink            req_bus,
   rid_rsp_if.source          rsp_bus
);

   logic        job_valid;
   logic        job_pop;
   rid_job_type job;

   rid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop)
   );

   rid_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp       (rsp_bus)
   );

endmodule

>>> hw/rtl/rid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_ram: generic single write, single read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module rid_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_front: request intake for the radix integer to digits block
// Holds the radix register, clamps it into 2..62 and queues each accepted
// value with its base in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rid_front
   import rid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [RADIX_W-1:0]  csr_wr_data,
   rid_req_if.sink             req,
   output logic                job_valid,
   output rid_job_type         job,
   input  logic                job_pop
);

   localparam int QDEPTH = 2;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] base;
   rid_job_type        job_ff [QDEPTH];
   logic [1:0]         fill_ff, fill_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic               push;

   always_comb begin
      radix_in = csr_wr_en ? csr_wr_data : radix_ff;
      if (radix_ff < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix_ff;
      end
   end

   assign req.ready = (fill_ff != 2'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign job_valid = (fill_ff != 2'd0);
   assign job       = job_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !job_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && job_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         radix_ff  <= radix_in;
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= '{value: req.value, base: base};
      end
   end

endmodule

>>> hw/rtl/rid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rid_back: divide and emit engine of the radix integer to digits block
// Divides the value by the base eight quotient bits a cycle, stores each
// remainder digit, then reads the digits back most significant first.
// ----------------------------------------------------------------------------
module rid_back
   import rid_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  rid_job_type job,
   output logic        job_pop,
   rid_rsp_if.source   rsp
);

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   rid_back_state_type      state_ff, state_in;
   logic [VALUE_W-1:0]      quot_ff, quot_in;
   logic [RADIX_W-1:0]      base_ff, base_in;
   logic [DIGIT_W-1:0]      rem_ff, rem_in;
   logic [STEP_CNT_W-1:0]   chunk_ff, chunk_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;

   logic [DIGIT_W-1:0]      rem_step;
   logic [STEP_BITS-1:0]    qbits;
   logic [VALUE_W-1:0]      quot_step;
   logic [CNT_W-1:0]        count_inc;

   logic                    wr_en;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DIGIT_W-1:0]      rd_data;

   // restoring divide, one quotient bit per step
   always_comb begin
      logic [DIGIT_W:0] t;
      rem_step = rem_ff;
      qbits    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {rem_step, quot_ff[VALUE_W-1-i]};
         if (t >= {1'b0, base_ff}) begin
            rem_step             = DIGIT_W'(t - {1'b0, base_ff});
            qbits[STEP_BITS-1-i] = 1'b1;
         end else begin
            rem_step = t[DIGIT_W-1:0];
         end
      end
      quot_step = {quot_ff[VALUE_W-STEP_BITS-1:0], qbits};
   end

   assign count_inc = count_ff + CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      job_pop  = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               quot_in  = job.value;
               base_in  = job.base;
               rem_in   = '0;
               chunk_in = '0;
               count_in = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            quot_in  = quot_step;
            rem_in   = rem_step;
            chunk_in = chunk_ff + STEP_CNT_W'(1);
            if (chunk_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               // one full division done: store the digit, go again or emit
               wr_en    = 1'b1;
               count_in = count_inc;
               rem_in   = '0;
               chunk_in = '0;
               if (quot_step == '0 || count_inc >= CNT_W'(MAX_DIGITS)) begin
                  state_in = BK_LOAD;
               end
            end
         end
         BK_LOAD: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
            idx_in   = rd_addr;
            state_in = BK_SHOW;
         end
         BK_SHOW: begin
            if (rsp.ready) begin
               if (idx_ff == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  // fetch the next digit as this word leaves
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - ADDR_W'(1);
                  idx_in  = rd_addr;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      base_ff  <= base_in;
      rem_ff   <= rem_in;
      chunk_ff <= chunk_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
   end

   rid_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (rem_step),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp.valid      = (state_ff == BK_SHOW);
   assign rsp.digit_char = digit_to_char(rd_data);
   assign rsp.last_digit = (idx_ff == '0);

endmodule
